// ===== design/lirc_pkg.sv =====
// lirc_pkg: shared constants, types and register codes of the linear
// interpolation rate converter
// no dependencies
package lirc_pkg;

	localparam int CHANNELS        = 2;
	localparam int PHASE_FRAC_BITS = 16;

	localparam int SMP_W   = 16;
	localparam int STEP_W  = 20;
	localparam int STEP_FB = 16;
	localparam int PHASE_W = PHASE_FRAC_BITS + 4;
	localparam int MAX_RUN = 16;
	localparam int RUN_W   = $clog2(MAX_RUN);
	localparam int CNT_W   = $clog2(PHASE_FRAC_BITS);
	localparam int DIFF_W  = SMP_W + 1;
	localparam int ACC_W   = SMP_W + 2;
	localparam int SUM_W   = SMP_W + 3;

	localparam int CFG_ADDR_W = 8;
	localparam int CFG_DATA_W = STEP_W;

	localparam logic [CFG_ADDR_W-1:0] REG_STEP_RATIO   = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_PASS_THROUGH = CFG_ADDR_W'(1);

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

	// control from the sequencer to each multiply lane
	typedef struct packed {
		logic load;
		logic shift;
	} lane_ctl_t;

endpackage

// ===== design/lirc_lane.sv =====
// lirc_lane: one channel of the interpolator, a bit-serial shift-add multiply
// of (cur - prev) by the phase fraction, then rounding and clamping
// depends on lirc_pkg
module lirc_lane (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  lirc_pkg::lane_ctl_t                     ctl,
	input  logic signed [lirc_pkg::SMP_W-1:0]       prev_smp,
	input  logic signed [lirc_pkg::SMP_W-1:0]       cur_smp,
	input  logic [lirc_pkg::PHASE_FRAC_BITS-1:0]    frac,
	output logic signed [lirc_pkg::SMP_W-1:0]       result
);

	logic signed [lirc_pkg::SMP_W-1:0]        base_q;
	logic signed [lirc_pkg::DIFF_W-1:0]       diff_q;
	logic signed [lirc_pkg::ACC_W-1:0]        acc_q;
	logic                                     rnd_q;
	logic [lirc_pkg::PHASE_FRAC_BITS-1:0]     frac_q;
	logic                                     busy_q;

	logic signed [lirc_pkg::ACC_W-1:0] addend;
	logic signed [lirc_pkg::ACC_W-1:0] sum;
	logic signed [lirc_pkg::SUM_W-1:0] total;

	localparam logic signed [lirc_pkg::SUM_W-1:0] SMP_MAX =
		lirc_pkg::SUM_W'((1 << (lirc_pkg::SMP_W - 1)) - 1);
	localparam logic signed [lirc_pkg::SUM_W-1:0] SMP_MIN = -SMP_MAX - 1;

	assign addend = frac_q[0] ? lirc_pkg::ACC_W'(diff_q) : '0;
	assign sum    = acc_q + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (ctl.load) begin
			busy_q <= 1'b1;
		end
	end

	// lsb-first multiply: the bit shifted out last is the rounding bit
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			base_q <= prev_smp;
			diff_q <= lirc_pkg::DIFF_W'(cur_smp) - lirc_pkg::DIFF_W'(prev_smp);
			acc_q  <= '0;
			rnd_q  <= 1'b0;
			frac_q <= frac;
		end else if (ctl.shift && busy_q) begin
			acc_q  <= sum >>> 1;
			rnd_q  <= sum[0];
			frac_q <= frac_q >> 1;
		end
	end

	always_comb begin
		total = lirc_pkg::SUM_W'(base_q) + lirc_pkg::SUM_W'(acc_q)
			+ lirc_pkg::SUM_W'({1'b0, rnd_q});
		if (total > SMP_MAX) begin
			result = lirc_pkg::SMP_W'(SMP_MAX);
		end else if (total < SMP_MIN) begin
			result = lirc_pkg::SMP_W'(SMP_MIN);
		end else begin
			result = total[lirc_pkg::SMP_W-1:0];
		end
	end

endmodule

// ===== design/linear_interp_rate_converter.sv =====
// linear_interp_rate_converter: top level, phase sequencer, config registers,
// output register and the per-channel bit-serial lanes
// depends on lirc_pkg and lirc_lane
//
// channel  | direction | handshake           | contents
// s_axis   | in        | s_tvalid/s_tready   | tdata: left_in, right_in; tlast: frame_last
// m_axis   | out       | m_tvalid/m_tready   | tdata: left_out, right_out; tlast: last_of_run
// cfg      | in        | cfg_valid/cfg_ready | cfg_addr register index, cfg_data value
//
// each interpolated result takes 16 multiply steps of the serial lanes
// (ST_MUL) followed by an output step (ST_OUT); a frame gives up to 16
// results; pass-through frames and frames that give no result skip the
// multiply and leave the sequencer in ST_IDLE
// reset clears phase and previous frame and sets the config registers to defaults; no clearing pass
// a stalled output holds the lanes in their output cycle until the register frees
module linear_interp_rate_converter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [2*lirc_pkg::SMP_W-1:0]         s_tdata,   // left_in, right_in
	input  logic                                 s_tlast,   // frame_last
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [2*lirc_pkg::SMP_W-1:0]         m_tdata,   // left_out, right_out
	output logic                                 m_tlast,   // last_of_run
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lirc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [lirc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int PFB = lirc_pkg::PHASE_FRAC_BITS;
	localparam int PW  = lirc_pkg::PHASE_W;
	localparam int SW  = lirc_pkg::SMP_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t state_q;

	logic [lirc_pkg::STEP_W-1:0]        step_q;
	logic                               pass_q;
	logic [PW-1:0]                      phase_q;
	logic signed [SW-1:0]               prev_q [lirc_pkg::CHANNELS];
	logic signed [SW-1:0]               cur_q  [lirc_pkg::CHANNELS];
	logic [lirc_pkg::CNT_W-1:0]         cnt_q;
	logic [lirc_pkg::RUN_W-1:0]         run_q;

	logic                               m_tvalid_q;
	logic [2*SW-1:0]                    m_tdata_q;
	logic                               m_tlast_q;

	logic [PW-1:0]                      step_scaled;
	logic [PW:0]                        phase_sum;
	logic [PW-1:0]                      phase_next;
	logic                               out_free;
	logic                               in_xact;
	logic                               phase_low;
	logic                               run_end;
	logic                               out_fire;
	logic signed [SW-1:0]               in_smp   [lirc_pkg::CHANNELS];
	logic signed [SW-1:0]               lane_cur [lirc_pkg::CHANNELS];
	logic signed [SW-1:0]               lane_res [lirc_pkg::CHANNELS];
	logic [PFB-1:0]                     lane_frac;
	lirc_pkg::lane_ctl_t                lane_ctl;
	logic [2*SW-1:0]                    res_data;

	// step from 16 fraction bits to the phase format
	generate
		if (PFB > lirc_pkg::STEP_FB) begin : g_step_up
			assign step_scaled = {step_q, (PFB - lirc_pkg::STEP_FB)'(0)};
		end else if (PFB == lirc_pkg::STEP_FB) begin : g_step_eq
			assign step_scaled = step_q;
		end else begin : g_step_dn
			assign step_scaled = step_q[lirc_pkg::STEP_W-1 -: PW];
		end
	endgenerate

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= lirc_pkg::STEP_RESET;
			pass_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_addr)
				lirc_pkg::REG_STEP_RATIO:   step_q <= cfg_data;
				lirc_pkg::REG_PASS_THROUGH: pass_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && (!pass_q || out_free);
	assign in_xact   = s_tvalid && s_tready;
	assign phase_low = (phase_q[PW-1:PFB] == '0);

	// saturating phase advance
	assign phase_sum  = {1'b0, phase_q} + {1'b0, step_scaled};
	assign phase_next = phase_sum[PW] ? {PW{1'b1}} : phase_sum[PW-1:0];
	assign run_end    = (phase_next[PW-1:PFB] != '0)
		|| (run_q == lirc_pkg::RUN_W'(lirc_pkg::MAX_RUN - 1));
	assign out_fire   = (state_q == ST_OUT) && out_free;

	genvar ch;
	generate
		for (ch = 0; ch < lirc_pkg::CHANNELS; ch++) begin : g_lane
			assign in_smp[ch]   = s_tdata[ch*SW +: SW];
			assign lane_cur[ch] = (state_q == ST_IDLE) ? in_smp[ch] : cur_q[ch];

			lirc_lane u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (lane_ctl),
				.prev_smp (prev_q[ch]),
				.cur_smp  (lane_cur[ch]),
				.frac     (lane_frac),
				.result   (lane_res[ch])
			);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					prev_q[ch] <= '0;
				end else if ((state_q == ST_IDLE && in_xact && !pass_q && !phase_low)
					|| (out_fire && run_end)) begin
					prev_q[ch] <= lane_cur[ch];
				end
			end

			always_ff @(posedge clk) begin
				if (in_xact) begin
					cur_q[ch] <= in_smp[ch];
				end
			end
		end
		if (lirc_pkg::CHANNELS >= 2) begin : g_stereo
			assign res_data = {lane_res[1], lane_res[0]};
		end else begin : g_mono
			assign res_data = {SW'(0), lane_res[0]};
		end
	endgenerate

	assign lane_frac      = (state_q == ST_IDLE) ? phase_q[PFB-1:0] : phase_next[PFB-1:0];
	assign lane_ctl.load  = (in_xact && !pass_q && phase_low) || (out_fire && !run_end);
	assign lane_ctl.shift = (state_q == ST_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			cnt_q   <= '0;
			run_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xact && !pass_q) begin
						if (phase_low) begin
							state_q <= ST_MUL;
							cnt_q   <= '0;
							run_q   <= '0;
						end else begin
							// no result for this frame
							phase_q <= phase_q - PW'(1 << PFB);
						end
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == lirc_pkg::CNT_W'(PFB - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						if (run_end) begin
							state_q <= ST_IDLE;
							// run cut short by the result cap drops the phase to zero
							phase_q <= (phase_next[PW-1:PFB] != '0)
								? phase_next - PW'(1 << PFB) : '0;
						end else begin
							state_q <= ST_MUL;
							phase_q <= phase_next;
							cnt_q   <= '0;
							run_q   <= run_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_fire || (in_xact && pass_q)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xact && pass_q) begin
			m_tdata_q <= (lirc_pkg::CHANNELS >= 2) ? s_tdata : {SW'(0), s_tdata[SW-1:0]};
			m_tlast_q <= 1'b1;
		end else if (out_fire) begin
			m_tdata_q <= res_data;
			m_tlast_q <= run_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule
